// ===== rtl/acs_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the archive cell scanner.
`timescale 1ns / 1ps

package acs_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_CELL_BYTES      = 2'd0;
    localparam logic [1:0] REG_CELL_COUNT      = 2'd1;
    localparam logic [1:0] REG_ARCHIVE_VERSION = 2'd2;

    // Register reset values and legal limits
    localparam logic [12:0] RESET_CELL_BYTES      = 13'd256;
    localparam logic [8:0]  RESET_CELL_COUNT      = 9'd4;
    localparam logic [7:0]  RESET_ARCHIVE_VERSION = 8'd1;
    localparam logic [12:0] MIN_CELL_BYTES        = 13'd8;
    localparam logic [12:0] MAX_CELL_BYTES        = 13'd4096;
    localparam logic [8:0]  MIN_CELLS             = 9'd1;
    localparam logic [8:0]  MAX_CELLS             = 9'd256;

    // Newest-cell index after reset: reset cell count minus one
    localparam logic [8:0] NEWEST_RESET_WIDE = RESET_CELL_COUNT - 9'd1;
    localparam logic [7:0] NEWEST_RESET      = NEWEST_RESET_WIDE[7:0];

    // CRC-16 CCITT-FALSE
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [31:0] STAMP_MIN_INIT = 32'hFFFF_FFFF;

    // One result item
    typedef struct packed {
        logic [7:0]  cell_index;
        logic        cell_valid;
        logic [31:0] cell_stamp;
        logic [8:0]  valid_count;
        logic [7:0]  oldest_index;
        logic [7:0]  newest_index;
        logic [31:0] newest_stamp;
        logic        scan_done;
    } result_t;

    // Bytewise CRC update, MSB first, no reflection
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (r[15]) begin
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/archive_cell_scanner.sv =====
// Top level of the archive cell scanner: byte intake, trailer check, tracking.
`timescale 1ns / 1ps

// Takes one archive byte per clock on the s_ channel and, on the last byte of
// each cell, emits one result item on the m_ channel. The item shows on the
// m_ channel the cycle after that byte is accepted, or later while m_tready
// holds earlier items back. The CRC-16 byte update, trailer capture and stamp
// tracking all sit between the state registers and the result registers, so a
// new byte can be accepted every cycle. Results pass through an output
// register and a skid register; s_tready drops only while both hold an item.
// s_tuser marks the first byte of a scan and clears all tracking before that
// byte is taken in; after the last cell of the ring the tracking clears by
// itself. Write the configuration registers only while no byte is in flight.
module archive_cell_scanner (
    input  logic         aclk,
    input  logic         aresetn,
    // Configuration write port
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [12:0]  cfg_wdata,
    // Byte input
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tuser,   // [0] area_start
    // Cell results
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // [7:0] cell_index, [39:8] cell_stamp,
                                    // [48:40] valid_count, [56:49] oldest_index,
                                    // [64:57] newest_index, [96:65] newest_stamp,
                                    // [103:97] zero
    output logic         m_tuser,   // [0] cell_valid
    output logic         m_tlast    // scan_done
);

    // Configuration registers
    logic [12:0] cell_bytes_reg;
    logic [8:0]  cell_count_reg;
    logic [7:0]  archive_version_reg;

    // Tracking state
    logic [15:0] crc_reg, crc_next;
    logic [11:0] byte_position_reg, byte_position_next;
    logic [63:0] trailer_reg, trailer_next;
    logic [7:0]  current_cell_reg, current_cell_next;
    logic [8:0]  good_cells_reg, good_cells_next;
    logic [31:0] min_stamp_reg, min_stamp_next;
    logic [31:0] max_stamp_reg, max_stamp_next;
    logic [7:0]  oldest_cell_reg, oldest_cell_next;
    logic [7:0]  newest_cell_reg, newest_cell_next;

    logic        accept;
    logic        buf_ready;
    logic [12:0] eff_bytes;
    logic [8:0]  eff_count;
    logic [8:0]  count_m1;

    // State after an optional start-of-scan clear
    logic [15:0] base_crc;
    logic [11:0] base_pos;
    logic [63:0] base_trailer;
    logic [7:0]  base_cell;
    logic [8:0]  base_good;
    logic [31:0] base_min;
    logic [31:0] base_max;
    logic [7:0]  base_oldest;
    logic [7:0]  base_newest;

    logic [63:0] shifted;
    logic [15:0] crc_upd;
    logic        last_byte;
    logic        ring_last;
    logic [31:0] stamp;
    logic [7:0]  sum;
    logic        ok;
    logic        hit_max;
    logic        hit_min;
    logic [8:0]  good_upd;
    logic [31:0] max_upd;
    logic [31:0] min_upd;
    logic [7:0]  newest_upd;
    logic [7:0]  oldest_upd;

    acs_pkg::result_t res;
    acs_pkg::result_t out_res;
    logic             res_valid;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = buf_ready;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_bytes_reg      <= acs_pkg::RESET_CELL_BYTES;
            cell_count_reg      <= acs_pkg::RESET_CELL_COUNT;
            archive_version_reg <= acs_pkg::RESET_ARCHIVE_VERSION;
        end else if (cfg_we) begin
            case (cfg_index)
                acs_pkg::REG_CELL_BYTES:      cell_bytes_reg      <= cfg_wdata;
                acs_pkg::REG_CELL_COUNT:      cell_count_reg      <= cfg_wdata[8:0];
                acs_pkg::REG_ARCHIVE_VERSION: archive_version_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Clamp registers to their legal ranges
    always_comb begin
        if (cell_bytes_reg < acs_pkg::MIN_CELL_BYTES) begin
            eff_bytes = acs_pkg::MIN_CELL_BYTES;
        end else if (cell_bytes_reg > acs_pkg::MAX_CELL_BYTES) begin
            eff_bytes = acs_pkg::MAX_CELL_BYTES;
        end else begin
            eff_bytes = cell_bytes_reg;
        end
        if (cell_count_reg < acs_pkg::MIN_CELLS) begin
            eff_count = acs_pkg::MIN_CELLS;
        end else if (cell_count_reg > acs_pkg::MAX_CELLS) begin
            eff_count = acs_pkg::MAX_CELLS;
        end else begin
            eff_count = cell_count_reg;
        end
    end

    assign count_m1 = eff_count - 9'd1;

    // Start of scan clears tracking before the byte is taken in
    always_comb begin
        if (s_tuser) begin
            base_crc     = acs_pkg::CRC_INIT;
            base_pos     = '0;
            base_trailer = '0;
            base_cell    = '0;
            base_good    = '0;
            base_min     = acs_pkg::STAMP_MIN_INIT;
            base_max     = '0;
            base_oldest  = '0;
            base_newest  = count_m1[7:0];
        end else begin
            base_crc     = crc_reg;
            base_pos     = byte_position_reg;
            base_trailer = trailer_reg;
            base_cell    = current_cell_reg;
            base_good    = good_cells_reg;
            base_min     = min_stamp_reg;
            base_max     = max_stamp_reg;
            base_oldest  = oldest_cell_reg;
            base_newest  = newest_cell_reg;
        end
    end

    // Byte intake: trailer shift and CRC over all but the last two bytes
    assign shifted   = {s_tdata, base_trailer[63:8]};
    assign crc_upd   = ({1'b0, base_pos} < (eff_bytes - 13'd2)) ?
                       acs_pkg::crc16_byte(base_crc, s_tdata) : base_crc;
    assign last_byte = {1'b0, base_pos} >= (eff_bytes - 13'd1);
    assign ring_last = {1'b0, base_cell} >= count_m1;

    // Trailer check
    assign stamp = shifted[31:0];
    assign sum   = shifted[7:0] + shifted[15:8] + shifted[23:16] + shifted[31:24]
                 + shifted[39:32];
    assign ok    = (sum == shifted[47:40]) && (shifted[39:32] == archive_version_reg)
                && (stamp != 32'd0) && (shifted[63:48] == crc_upd);

    // Tracking update; first cell with an extreme stamp wins on ties
    assign hit_max    = ok && (stamp > base_max);
    assign hit_min    = ok && (stamp < base_min);
    assign good_upd   = base_good + {8'd0, ok};
    assign max_upd    = hit_max ? stamp : base_max;
    assign min_upd    = hit_min ? stamp : base_min;
    assign newest_upd = hit_max ? base_cell : base_newest;
    assign oldest_upd = hit_min ? base_cell : base_oldest;

    // Result item
    always_comb begin
        res.cell_index   = base_cell;
        res.cell_valid   = ok;
        res.cell_stamp   = ok ? stamp : 32'd0;
        res.valid_count  = good_upd;
        res.oldest_index = oldest_upd;
        res.newest_index = newest_upd;
        res.newest_stamp = (max_upd != 32'd0) ? max_upd : 32'd1;
        res.scan_done    = ring_last;
    end

    assign res_valid = accept && last_byte;

    // Next tracking state
    always_comb begin
        crc_next           = crc_reg;
        byte_position_next = byte_position_reg;
        trailer_next       = trailer_reg;
        current_cell_next  = current_cell_reg;
        good_cells_next    = good_cells_reg;
        min_stamp_next     = min_stamp_reg;
        max_stamp_next     = max_stamp_reg;
        oldest_cell_next   = oldest_cell_reg;
        newest_cell_next   = newest_cell_reg;
        if (accept) begin
            if (!last_byte) begin
                crc_next           = crc_upd;
                byte_position_next = base_pos + 12'd1;
                trailer_next       = shifted;
                current_cell_next  = base_cell;
                good_cells_next    = base_good;
                min_stamp_next     = base_min;
                max_stamp_next     = base_max;
                oldest_cell_next   = base_oldest;
                newest_cell_next   = base_newest;
            end else if (ring_last) begin
                crc_next           = acs_pkg::CRC_INIT;
                byte_position_next = '0;
                trailer_next       = '0;
                current_cell_next  = '0;
                good_cells_next    = '0;
                min_stamp_next     = acs_pkg::STAMP_MIN_INIT;
                max_stamp_next     = '0;
                oldest_cell_next   = '0;
                newest_cell_next   = count_m1[7:0];
            end else begin
                crc_next           = acs_pkg::CRC_INIT;
                byte_position_next = '0;
                trailer_next       = '0;
                current_cell_next  = base_cell + 8'd1;
                good_cells_next    = good_upd;
                min_stamp_next     = min_upd;
                max_stamp_next     = max_upd;
                oldest_cell_next   = oldest_upd;
                newest_cell_next   = newest_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg           <= acs_pkg::CRC_INIT;
            byte_position_reg <= '0;
            trailer_reg       <= '0;
            current_cell_reg  <= '0;
            good_cells_reg    <= '0;
            min_stamp_reg     <= acs_pkg::STAMP_MIN_INIT;
            max_stamp_reg     <= '0;
            oldest_cell_reg   <= '0;
            newest_cell_reg   <= acs_pkg::NEWEST_RESET;
        end else begin
            crc_reg           <= crc_next;
            byte_position_reg <= byte_position_next;
            trailer_reg       <= trailer_next;
            current_cell_reg  <= current_cell_next;
            good_cells_reg    <= good_cells_next;
            min_stamp_reg     <= min_stamp_next;
            max_stamp_reg     <= max_stamp_next;
            oldest_cell_reg   <= oldest_cell_next;
            newest_cell_reg   <= newest_cell_next;
        end
    end

    // Output buffering
    acs_result_buf u_result_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_ready  (buf_ready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    // Output packing
    assign m_tdata = {7'd0, out_res.newest_stamp, out_res.newest_index,
                      out_res.oldest_index, out_res.valid_count, out_res.cell_stamp,
                      out_res.cell_index};
    assign m_tuser = out_res.cell_valid;
    assign m_tlast = out_res.scan_done;

    // Input stalls only when the output register is also full
    a_stall_needs_full_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output register");

    // A valid cell always carries a nonzero stamp, an invalid one a zero stamp
    a_stamp_matches_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[39:8] != 32'd0) == m_tuser))
        else $error("cell stamp disagrees with cell verdict");

    // Valid count cannot exceed the number of cells seen in the scan
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[48:40] <= ({1'b0, m_tdata[7:0]} + 9'd1)))
        else $error("valid count exceeds cells scanned");

    // The newest stamp is never below the stamp of a valid cell
    a_newest_covers_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[96:65] >= m_tdata[39:8]))
        else $error("newest stamp below a valid cell stamp");

endmodule

// ===== rtl/acs_result_buf.sv =====
// Two-entry result buffer: output register plus skid register.
`timescale 1ns / 1ps

module acs_result_buf (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  acs_pkg::result_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output acs_pkg::result_t out_data
);

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    acs_pkg::result_t out_data_reg, out_data_next;
    acs_pkg::result_t skid_data_reg, skid_data_next;

    // Room for a new item as long as the skid slot is free
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Slot control
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (out_ready) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (in_valid) begin
            if (!out_valid_reg || out_ready) begin
                out_data_next  = in_data;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = in_data;
                skid_valid_next = 1'b1;
            end
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the archive cell scanner: trailer, CRC and ring tracking.
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_CYCLES = 1_000_000;
    localparam int RANDOM_ITEMS    = 1480;
    localparam int QUIET_AFTER     = 1200;
    localparam int SETTLE_CYCLES   = 6;
    localparam int MAX_REPORTS     = 10;

    // Ways a generated cell can be spoiled
    typedef enum int {
        FLAW_NONE,
        FLAW_SUM,
        FLAW_VERSION,
        FLAW_CRC,
        FLAW_JUNK
    } flaw_t;

    // Predicts cell verdicts and holds the ones not yet seen on the result channel
    class cell_scoreboard;
        int unsigned cfg_bytes;
        int unsigned cfg_count;
        logic [7:0]  cfg_version;

        logic [15:0] crc;
        int unsigned pos;
        logic [63:0] tail;
        int unsigned cur;
        int unsigned good;
        logic [31:0] lo_stamp;
        logic [31:0] hi_stamp;
        logic [7:0]  oldest;
        logic [7:0]  newest;

        acs_pkg::result_t verdicts_due[$];
        int               mismatches;
        int               seen;

        function new();
            cfg_bytes   = acs_pkg::RESET_CELL_BYTES;
            cfg_count   = acs_pkg::RESET_CELL_COUNT;
            cfg_version = acs_pkg::RESET_ARCHIVE_VERSION;
            mismatches  = 0;
            seen        = 0;
            clear_scan();
        endfunction

        // CCITT update, one data bit at a time
        static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] d);
            logic fb;
            for (int i = 7; i >= 0; i--) begin
                fb = c[15] ^ d[i];
                c  = {c[14:0], 1'b0};
                if (fb) begin
                    c = c ^ acs_pkg::CRC_POLY;
                end
            end
            return c;
        endfunction

        function int unsigned eff_bytes();
            if (cfg_bytes < acs_pkg::MIN_CELL_BYTES) return acs_pkg::MIN_CELL_BYTES;
            if (cfg_bytes > acs_pkg::MAX_CELL_BYTES) return acs_pkg::MAX_CELL_BYTES;
            return cfg_bytes;
        endfunction

        function int unsigned eff_count();
            if (cfg_count < acs_pkg::MIN_CELLS) return acs_pkg::MIN_CELLS;
            if (cfg_count > acs_pkg::MAX_CELLS) return acs_pkg::MAX_CELLS;
            return cfg_count;
        endfunction

        function void clear_scan();
            crc      = acs_pkg::CRC_INIT;
            pos      = 0;
            tail     = '0;
            cur      = 0;
            good     = 0;
            lo_stamp = acs_pkg::STAMP_MIN_INIT;
            hi_stamp = '0;
            oldest   = '0;
            newest   = 8'(eff_count() - 1);
        endfunction

        function void set_reg(logic [1:0] idx, logic [12:0] val);
            case (idx)
                acs_pkg::REG_CELL_BYTES:      cfg_bytes   = val;
                acs_pkg::REG_CELL_COUNT:      cfg_count   = val[8:0];
                acs_pkg::REG_ARCHIVE_VERSION: cfg_version = val[7:0];
                default: ;
            endcase
        endfunction

        // One accepted byte; queues a verdict when it closes a cell
        function void take_byte(logic [7:0] d, logic start);
            int unsigned      nb;
            int unsigned      nc;
            logic [31:0]      stamp;
            logic [7:0]       sum;
            logic             ok;
            logic             last;
            acs_pkg::result_t r;
            nb = eff_bytes();
            nc = eff_count();
            if (start) clear_scan();
            tail = {d, tail[63:8]};
            if (pos < nb - 2) crc = crc_step(crc, d);
            if (pos < nb - 1) begin
                pos++;
                return;
            end
            stamp = tail[31:0];
            sum   = tail[7:0] + tail[15:8] + tail[23:16] + tail[31:24] + tail[39:32];
            ok    = (sum == tail[47:40]) && (tail[39:32] == cfg_version) &&
                    (stamp != 0) && (tail[63:48] == crc);
            if (ok) begin
                good++;
                // first cell with a given extreme stamp keeps it
                if (stamp > hi_stamp) begin
                    hi_stamp = stamp;
                    newest   = 8'(cur);
                end
                if (stamp < lo_stamp) begin
                    lo_stamp = stamp;
                    oldest   = 8'(cur);
                end
            end
            last = (cur >= nc - 1);
            r.cell_index   = 8'(cur);
            r.cell_valid   = ok;
            r.cell_stamp   = ok ? stamp : 32'd0;
            r.valid_count  = 9'(good);
            r.oldest_index = oldest;
            r.newest_index = newest;
            r.newest_stamp = (hi_stamp != 0) ? hi_stamp : 32'd1;
            r.scan_done    = last;
            verdicts_due.push_back(r);
            if (last) begin
                clear_scan();
            end else begin
                cur  = (cur + 1) & 8'hFF;
                pos  = 0;
                crc  = acs_pkg::CRC_INIT;
                tail = '0;
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("result %0d: %s expected %0h, got %0h", seen, name, want, got);
                end
            end
        endfunction

        function void check_verdict(acs_pkg::result_t act);
            acs_pkg::result_t want;
            seen++;
            if (verdicts_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("result %0d: none expected, got cell %0d", seen, act.cell_index);
                end
                return;
            end
            want = verdicts_due.pop_front();
            compare_field("cell_index", want.cell_index, act.cell_index);
            compare_field("cell_valid", want.cell_valid, act.cell_valid);
            compare_field("cell_stamp", want.cell_stamp, act.cell_stamp);
            compare_field("valid_count", want.valid_count, act.valid_count);
            compare_field("oldest_index", want.oldest_index, act.oldest_index);
            compare_field("newest_index", want.newest_index, act.newest_index);
            compare_field("newest_stamp", want.newest_stamp, act.newest_stamp);
            compare_field("scan_done", want.scan_done, act.scan_done);
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [12:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;

    cell_scoreboard   sb;
    acs_pkg::result_t got_verdict;
    logic [7:0]       cell_buf [0:4095];
    logic [31:0]      last_stamp;
    bit               src_idle;
    bit               snk_idle;
    int               bytes_sent;

    archive_cell_scanner i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Result-side back-pressure in bursts
    always begin
        @(negedge aclk);
        if (snk_idle && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
            m_tready <= 1'b1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            got_verdict.cell_index   = m_tdata[7:0];
            got_verdict.cell_valid   = m_tuser;
            got_verdict.cell_stamp   = m_tdata[39:8];
            got_verdict.valid_count  = m_tdata[48:40];
            got_verdict.oldest_index = m_tdata[56:49];
            got_verdict.newest_index = m_tdata[64:57];
            got_verdict.newest_stamp = m_tdata[96:65];
            got_verdict.scan_done    = m_tlast;
            sb.check_verdict(got_verdict);
        end
    end

    initial begin : watchdog
        repeat (WATCHDOG_CYCLES) @(posedge aclk);
        $display("FAILURE");
        $finish;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // One byte, with an optional gap before it
    task automatic push_byte(input logic [7:0] d, input logic start);
        @(negedge aclk);
        if (src_idle && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= start;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.take_byte(d, start);
        bytes_sent++;
    endtask

    // Stop sending, wait for every verdict, then let the pipeline settle
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.verdicts_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_stamp();
        case ($urandom_range(0, 15))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'd1;
            3, 4:    return last_stamp;
            default: return $urandom;
        endcase
    endfunction

    function automatic flaw_t pick_flaw();
        case ($urandom_range(0, 19))
            0:       return FLAW_SUM;
            1:       return FLAW_VERSION;
            2:       return FLAW_CRC;
            3:       return FLAW_JUNK;
            default: return FLAW_NONE;
        endcase
    endfunction

    // Fill cell_buf with n bytes: payload, trailer, CRC
    task automatic build_cell(input int n, input flaw_t flaw, input logic [31:0] stamp);
        logic [15:0] c;
        logic [7:0]  sum;
        for (int i = 0; i < n - 8; i++) cell_buf[i] = 8'($urandom);
        last_stamp      = stamp;
        cell_buf[n - 8] = stamp[7:0];
        cell_buf[n - 7] = stamp[15:8];
        cell_buf[n - 6] = stamp[23:16];
        cell_buf[n - 5] = stamp[31:24];
        cell_buf[n - 4] = sb.cfg_version;
        if (flaw == FLAW_VERSION) cell_buf[n - 4] ^= 8'(1 << $urandom_range(0, 7));
        sum = cell_buf[n - 8] + cell_buf[n - 7] + cell_buf[n - 6] + cell_buf[n - 5] +
              cell_buf[n - 4];
        if (flaw == FLAW_SUM) sum ^= 8'(1 << $urandom_range(0, 7));
        cell_buf[n - 3] = sum;
        if (flaw == FLAW_JUNK) begin
            for (int i = n - 8; i < n - 2; i++) cell_buf[i] = 8'($urandom);
        end
        c = acs_pkg::CRC_INIT;
        for (int i = 0; i < n - 2; i++) c = cell_scoreboard::crc_step(c, cell_buf[i]);
        if (flaw == FLAW_CRC) c ^= 16'(1 << $urandom_range(0, 15));
        if (flaw == FLAW_JUNK) c = 16'($urandom);
        cell_buf[n - 2] = c[7:0];
        cell_buf[n - 1] = c[15:8];
    endtask

    // Send the first len bytes of a cell of n bytes
    task automatic send_cell(input int n, input flaw_t flaw, input logic [31:0] stamp,
                             input logic start, input int len);
        build_cell(n, flaw, stamp);
        for (int i = 0; i < len; i++) push_byte(cell_buf[i], start && i == 0);
    endtask

    task automatic reconfigure();
        if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 9))
                0:       write_reg(acs_pkg::REG_CELL_BYTES, 13'($urandom_range(0, 7)));
                1:       write_reg(acs_pkg::REG_CELL_BYTES, 13'($urandom_range(25, 40)));
                default: write_reg(acs_pkg::REG_CELL_BYTES, 13'($urandom_range(8, 24)));
            endcase
        end
        if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 9))
                0:       write_reg(acs_pkg::REG_CELL_COUNT, 13'd0);
                1:       write_reg(acs_pkg::REG_CELL_COUNT, 13'($urandom_range(255, 511)));
                default: write_reg(acs_pkg::REG_CELL_COUNT, 13'($urandom_range(1, 6)));
            endcase
        end
        if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 7))
                0:       write_reg(acs_pkg::REG_ARCHIVE_VERSION, 13'd0);
                1:       write_reg(acs_pkg::REG_ARCHIVE_VERSION, 13'd255);
                default: write_reg(acs_pkg::REG_ARCHIVE_VERSION, 13'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // Mostly whole cells; some cut short, some stray bytes, then a fresh scan marker
    task automatic run_scan();
        int   n;
        logic marker;
        n      = sb.eff_bytes();
        marker = ($urandom_range(0, 7) != 0);
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 9))
                0: begin
                    send_cell(n, pick_flaw(), pick_stamp(), marker, $urandom_range(1, n - 1));
                    marker = 1'b1;
                end
                1: begin
                    repeat ($urandom_range(1, 4)) begin
                        push_byte(8'($urandom), $urandom_range(0, 5) == 0);
                    end
                    marker = 1'b1;
                end
                default: begin
                    send_cell(n, pick_flaw(), pick_stamp(), marker, n);
                    marker = 1'b0;
                end
            endcase
        end
    endtask

    initial begin
        int  base;
        bit  quiet;
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = acs_pkg::REG_CELL_BYTES;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        m_tready   = 1'b0;
        src_idle   = 1'b0;
        snk_idle   = 1'b0;
        bytes_sent = 0;
        last_stamp = 32'd1;
        sb         = new();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: size below minimum, top version, equal top stamps, scan wrap, zero stamp
        write_reg(acs_pkg::REG_CELL_BYTES, 13'd3);
        write_reg(acs_pkg::REG_CELL_COUNT, 13'd2);
        write_reg(acs_pkg::REG_ARCHIVE_VERSION, 13'd255);
        send_cell(8, FLAW_NONE, 32'hFFFF_FFFF, 1'b1, 8);
        send_cell(8, FLAW_NONE, 32'hFFFF_FFFF, 1'b0, 8);
        send_cell(8, FLAW_NONE, 32'd0, 1'b0, 8);
        drain();

        // Count above maximum: the ring must not end early
        src_idle = 1'b1;
        snk_idle = 1'b1;
        write_reg(acs_pkg::REG_CELL_BYTES, 13'd8);
        write_reg(acs_pkg::REG_CELL_COUNT, 13'd511);
        write_reg(acs_pkg::REG_ARCHIVE_VERSION, 13'd0);
        for (int c = 0; c < 12; c++) send_cell(8, pick_flaw(), pick_stamp(), c == 0, 8);
        drain();

        // Size above maximum with count below minimum, then a smaller size closes the cell
        write_reg(acs_pkg::REG_CELL_BYTES, 13'd8191);
        write_reg(acs_pkg::REG_CELL_COUNT, 13'd0);
        for (int i = 0; i < 40; i++) push_byte(8'($urandom), i == 0);
        drain();
        write_reg(acs_pkg::REG_CELL_BYTES, 13'd8);
        push_byte(8'($urandom), 1'b0);
        drain();

        // Random scans under changing settings; no idling near the end
        write_reg(acs_pkg::REG_CELL_BYTES, 13'd12);
        write_reg(acs_pkg::REG_CELL_COUNT, 13'd3);
        base = bytes_sent;
        while (bytes_sent - base < RANDOM_ITEMS) begin
            quiet    = (bytes_sent - base >= QUIET_AFTER);
            src_idle = !quiet && $urandom_range(0, 3) != 0;
            snk_idle = !quiet && $urandom_range(0, 3) != 0;
            drain();
            if ($urandom_range(0, 1) != 0) reconfigure();
            run_scan();
        end
        drain();

        if (sb.mismatches == 0 && sb.verdicts_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
